FILE: rtl/lcas_pkg.sv
// Shared types and constants for the life automaton stencil.
package lcas_pkg;

   localparam int CFG_WIDTH = 11;
   localparam int ROW_WIDTH = 11;
   localparam int COORD_WIDTH = 10;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int FRAME_RESET = 1024;
   localparam int MIN_DIM = 3;
   localparam int MAX_HEIGHT = 1024;
   localparam int COUNT_WIDTH = 4;
   localparam logic [COUNT_WIDTH-1:0] BIRTH_COUNT = 4'd3;
   localparam logic [COUNT_WIDTH-1:0] SURVIVE_COUNT = 4'd2;
   localparam int QUEUE_DEPTH = 3;
   localparam int QUEUE_PTR_WIDTH = 2;
   localparam int QUEUE_FILL_WIDTH = 2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                   next_alive;
      logic [COORD_WIDTH-1:0] out_column;
      logic [COORD_WIDTH-1:0] out_row;
      logic                   last_of_frame;
   } result_type;

endpackage

FILE: rtl/lcas_req_if.sv
// Input channel carrying one padded-frame cell per beat.
interface lcas_req_if;
   logic valid;
   logic ready;
   logic cell_alive;
   logic start_of_frame;

   modport source (output valid, output cell_alive, output start_of_frame, input ready);
   modport sink (input valid, input cell_alive, input start_of_frame, output ready);
endinterface

FILE: rtl/lcas_rsp_if.sv
// Result channel carrying one next-generation cell per beat.
interface lcas_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               next_alive;
   logic [lcas_pkg::COORD_WIDTH-1:0]   out_column;
   logic [lcas_pkg::COORD_WIDTH-1:0]   out_row;
   logic                               last_of_frame;

   modport source (output valid, output next_alive, output out_column, output out_row,
                   output last_of_frame, input ready);
   modport sink (input valid, input next_alive, input out_column, input out_row,
                 input last_of_frame, output ready);
endinterface

FILE: rtl/lcas_rsp_queue.sv
// Three-entry result queue that decouples the stencil pipeline from the result channel.
module lcas_rsp_queue (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     push_valid,
   input  lcas_pkg::result_type                     push_data,
   output logic [lcas_pkg::QUEUE_FILL_WIDTH-1:0]    fill_level,
   lcas_rsp_if.source                               rsp
);

   localparam logic [lcas_pkg::QUEUE_PTR_WIDTH-1:0] LAST_SLOT =
      lcas_pkg::QUEUE_PTR_WIDTH'(lcas_pkg::QUEUE_DEPTH - 1);

   lcas_pkg::result_type                        entries_ff [lcas_pkg::QUEUE_DEPTH];
   logic [lcas_pkg::QUEUE_PTR_WIDTH-1:0]        head_ff;
   logic [lcas_pkg::QUEUE_PTR_WIDTH-1:0]        head_in;
   logic [lcas_pkg::QUEUE_PTR_WIDTH-1:0]        tail_ff;
   logic [lcas_pkg::QUEUE_PTR_WIDTH-1:0]        tail_in;
   logic [lcas_pkg::QUEUE_FILL_WIDTH-1:0]       count_ff;
   logic [lcas_pkg::QUEUE_FILL_WIDTH-1:0]       count_in;
   logic                                        pop;
   lcas_pkg::result_type                        head_data;

   assign pop = rsp.valid && rsp.ready;
   assign head_data = entries_ff[head_ff];

   assign rsp.valid = (count_ff != '0);
   assign rsp.next_alive = head_data.next_alive;
   assign rsp.out_column = head_data.out_column;
   assign rsp.out_row = head_data.out_row;
   assign rsp.last_of_frame = head_data.last_of_frame;
   assign fill_level = count_ff;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      if (pop) begin
         head_in = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
      end
      if (push_valid) begin
         tail_in = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;
      end
      count_in = count_ff + lcas_pkg::QUEUE_FILL_WIDTH'(push_valid)
                 - lcas_pkg::QUEUE_FILL_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[tail_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/life_cellular_automaton_stencil.sv
// Top level of the B3/S23 life stencil over a streamed padded bit map.
//
// The block takes one padded-frame cell per clock in raster order while req.ready is high, and
// returns the next state of each interior cell once its 3x3 neighborhood is complete. The
// two line stores share one single-port-read memory of MAX_WIDTH+2 two-bit entries, read
// on acceptance and written back in the cycle after, with the written entry forwarded when
// the next cell reads the same column. A result passes through the s1 registers and waits
// in a three-entry queue before it appears on the result channel. After reset the block
// clears every line-store entry and accepts no cells during that time; register writes
// are taken at any time.
module life_cellular_automaton_stencil #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                    clock,
   input  logic                                    reset,
   lcas_req_if.sink                                req,
   lcas_rsp_if.source                              rsp,
   input  logic                                    csr_write_enable,
   input  logic [lcas_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [lcas_pkg::CFG_WIDTH-1:0]          csr_data
);

   localparam int STORE_DEPTH = MAX_WIDTH + 2;
   localparam int ADDR_WIDTH = $clog2(STORE_DEPTH);
   localparam int COL_WIDTH = $clog2(MAX_WIDTH + 3);
   localparam int RESET_WIDTH = (lcas_pkg::FRAME_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                                     : lcas_pkg::FRAME_RESET;
   localparam int RESET_HEIGHT = (lcas_pkg::FRAME_RESET > lcas_pkg::MAX_HEIGHT)
                                 ? lcas_pkg::MAX_HEIGHT : lcas_pkg::FRAME_RESET;
   localparam int RW = lcas_pkg::ROW_WIDTH;
   localparam logic [ADDR_WIDTH-1:0] LAST_ADDR = ADDR_WIDTH'(STORE_DEPTH - 1);

   logic [COL_WIDTH-1:0]                  pad_width_ff;
   logic [COL_WIDTH-1:0]                  pad_width_in;
   logic [RW-1:0]                         pad_height_ff;
   logic [RW-1:0]                         pad_height_in;

   logic [COL_WIDTH-1:0]                  col_ff;
   logic [COL_WIDTH-1:0]                  col_in;
   logic [RW-1:0]                         row_ff;
   logic [RW-1:0]                         row_in;

   logic                                  clearing_ff;
   logic [ADDR_WIDTH-1:0]                 clear_addr_ff;

   logic [1:0]                            line_mem [STORE_DEPTH];
   logic [1:0]                            rd_data_ff;
   logic                                  fwd_ff;
   logic                                  fwd_in;
   logic [1:0]                            fwd_data_ff;

   logic                                  s1_valid_ff;
   logic [ADDR_WIDTH-1:0]                 s1_addr_ff;
   logic                                  s1_cur_ff;
   logic                                  s1_emit_ff;
   logic                                  s1_last_ff;
   logic [lcas_pkg::COORD_WIDTH-1:0]      s1_col_ff;
   logic [lcas_pkg::COORD_WIDTH-1:0]      s1_row_ff;

   logic [8:0]                            window_ff;
   logic [8:0]                            window_in;

   logic                                  accept;
   logic [COL_WIDTH-1:0]                  c_pos;
   logic [RW-1:0]                         r_pos;
   logic [COL_WIDTH-1:0]                  c_step;
   logic [RW-1:0]                         r_step;
   logic                                  border;
   logic                                  cur_alive;
   logic                                  emit;
   logic                                  last;
   logic [ADDR_WIDTH-1:0]                 rd_addr;

   logic [1:0]                            line_data;
   logic [lcas_pkg::COUNT_WIDTH-1:0]      neighbors;
   logic                                  next_state;
   logic                                  mem_we;
   logic [ADDR_WIDTH-1:0]                 mem_waddr;
   logic [1:0]                            mem_wdata;

   logic [lcas_pkg::QUEUE_FILL_WIDTH-1:0] fill_level;
   lcas_pkg::result_type                  push_data;

   // Register writes are clamped to the legal range and kept as padded dimensions.
   always_comb begin
      pad_width_in = pad_width_ff;
      pad_height_in = pad_height_ff;
      if (csr_write_enable) begin
         unique case (lcas_pkg::csr_index_type'(csr_index))
            lcas_pkg::REG_FRAME_WIDTH: begin
               if (int'(csr_data) < lcas_pkg::MIN_DIM) begin
                  pad_width_in = COL_WIDTH'(lcas_pkg::MIN_DIM + 2);
               end else if (int'(csr_data) > MAX_WIDTH) begin
                  pad_width_in = COL_WIDTH'(MAX_WIDTH + 2);
               end else begin
                  pad_width_in = COL_WIDTH'(int'(csr_data) + 2);
               end
            end
            lcas_pkg::REG_FRAME_HEIGHT: begin
               if (int'(csr_data) < lcas_pkg::MIN_DIM) begin
                  pad_height_in = RW'(lcas_pkg::MIN_DIM + 2);
               end else if (int'(csr_data) > lcas_pkg::MAX_HEIGHT) begin
                  pad_height_in = RW'(lcas_pkg::MAX_HEIGHT + 2);
               end else begin
                  pad_height_in = RW'(int'(csr_data) + 2);
               end
            end
         endcase
      end
   end

   assign req.ready = !clearing_ff
                      && ((3'(fill_level) + 3'(s1_valid_ff)) < 3'(lcas_pkg::QUEUE_DEPTH));
   assign accept = req.valid && req.ready;

   // Position of the arriving cell, then the position of the one after it.
   always_comb begin
      c_pos = req.start_of_frame ? '0 : col_ff;
      r_pos = req.start_of_frame ? '0 : row_ff;
      if (c_pos >= pad_width_ff) begin
         c_pos = '0;
         r_pos = r_pos + 1'b1;
      end
      if (r_pos >= pad_height_ff) begin
         r_pos = '0;
      end

      c_step = c_pos + 1'b1;
      r_step = r_pos;
      if (c_step >= pad_width_ff) begin
         c_step = '0;
         r_step = r_pos + 1'b1;
         if (r_step >= pad_height_ff) begin
            r_step = '0;
         end
      end

      border = (c_pos == '0) || (r_pos == '0) || (c_pos == pad_width_ff - 1'b1)
               || (r_pos == pad_height_ff - 1'b1);
      cur_alive = req.cell_alive && !border;
      emit = (r_pos >= RW'(2)) && (c_pos >= COL_WIDTH'(2));
      last = (r_pos == pad_height_ff - 1'b1) && (c_pos == pad_width_ff - 1'b1);
      rd_addr = c_pos[ADDR_WIDTH-1:0];
      col_in = accept ? c_step : col_ff;
      row_in = accept ? r_step : row_ff;
   end

   // In s1, line-store data arrives, the window shifts and the entry is written back.
   always_comb begin
      line_data = fwd_ff ? fwd_data_ff : rd_data_ff;
      window_in = {window_ff[7:6], s1_cur_ff, window_ff[4:3], line_data[0],
                   window_ff[1:0], line_data[1]};
      neighbors = lcas_pkg::COUNT_WIDTH'($countones({window_in[8:5], window_in[3:0]}));
      next_state = (neighbors == lcas_pkg::BIRTH_COUNT)
                   || (window_in[4] && (neighbors == lcas_pkg::SURVIVE_COUNT));
      fwd_in = accept && s1_valid_ff && (s1_addr_ff == rd_addr);

      mem_we = clearing_ff || s1_valid_ff;
      mem_waddr = clearing_ff ? clear_addr_ff : s1_addr_ff;
      mem_wdata = clearing_ff ? 2'b00 : {line_data[0], s1_cur_ff};

      push_data.next_alive = next_state;
      push_data.out_column = s1_col_ff;
      push_data.out_row = s1_row_ff;
      push_data.last_of_frame = s1_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_width_ff <= COL_WIDTH'(RESET_WIDTH + 2);
         pad_height_ff <= RW'(RESET_HEIGHT + 2);
         col_ff <= '0;
         row_ff <= '0;
         clearing_ff <= 1'b1;
         clear_addr_ff <= '0;
         s1_valid_ff <= 1'b0;
         fwd_ff <= 1'b0;
         window_ff <= '0;
      end else begin
         pad_width_ff <= pad_width_in;
         pad_height_ff <= pad_height_in;
         col_ff <= col_in;
         row_ff <= row_in;
         if (clearing_ff) begin
            clear_addr_ff <= clear_addr_ff + 1'b1;
            if (clear_addr_ff == LAST_ADDR) begin
               clearing_ff <= 1'b0;
            end
         end
         s1_valid_ff <= accept;
         fwd_ff <= fwd_in;
         if (s1_valid_ff) begin
            window_ff <= window_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff <= rd_addr;
         s1_cur_ff <= cur_alive;
         s1_emit_ff <= emit;
         s1_last_ff <= last;
         s1_col_ff <= lcas_pkg::COORD_WIDTH'(32'(c_pos) - 32'd2);
         s1_row_ff <= lcas_pkg::COORD_WIDTH'(r_pos - RW'(2));
      end
      fwd_data_ff <= {line_data[0], s1_cur_ff};
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[mem_waddr] <= mem_wdata;
      end
      if (accept) begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   lcas_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (s1_valid_ff && s1_emit_ff),
      .push_data  (push_data),
      .fill_level (fill_level),
      .rsp        (rsp)
   );

endmodule

FILE: sim/life_cellular_automaton_stencil_test.sv
// Self-checking testbench for the life stencil: random padded frames against a built-in predictor.
module life_cellular_automaton_stencil_test;

   localparam int MAX_WIDTH = 1024;
   localparam int STORE_DEPTH = MAX_WIDTH + 2;

   typedef struct packed {
      logic cell_alive;
      logic start_of_frame;
   } cell_beat_type;

   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_PERIODIC
   } ready_pattern_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [lcas_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [lcas_pkg::CFG_WIDTH-1:0] csr_data;

   lcas_req_if req();
   lcas_rsp_if rsp();

   life_cellular_automaton_stencil DUT (
      .clock            (clock),
      .reset            (reset),
      .req              (req),
      .rsp              (rsp),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #1 clock = ~clock;

   cell_beat_type cells_to_send[$];
   lcas_pkg::result_type expected_next_states[$];
   int mismatch_count = 0;

   logic [lcas_pkg::CFG_WIDTH-1:0] width_setting =
      lcas_pkg::CFG_WIDTH'(lcas_pkg::FRAME_RESET);
   logic [lcas_pkg::CFG_WIDTH-1:0] height_setting =
      lcas_pkg::CFG_WIDTH'(lcas_pkg::FRAME_RESET);
   logic upper_line[STORE_DEPTH];
   logic middle_line[STORE_DEPTH];
   logic [8:0] neighborhood = '0;
   int unsigned column_pos = 0;
   int unsigned row_pos = 0;

   initial begin
      foreach (upper_line[i]) begin
         upper_line[i] = 1'b0;
         middle_line[i] = 1'b0;
      end
   end

   function automatic int unsigned clamp_dim(logic [lcas_pkg::CFG_WIDTH-1:0] value,
                                             int unsigned limit);
      if (value < lcas_pkg::MIN_DIM) return lcas_pkg::MIN_DIM;
      if (value > limit) return limit;
      return 32'(value);
   endfunction

   function automatic void advance_cell(logic alive_in, logic start);
      int unsigned padded_w;
      int unsigned padded_h;
      int unsigned c;
      int unsigned r;
      logic alive;
      logic top;
      logic mid;
      logic [lcas_pkg::COUNT_WIDTH-1:0] live_neighbors;
      lcas_pkg::result_type outcome;
      padded_w = clamp_dim(width_setting, MAX_WIDTH) + 2;
      padded_h = clamp_dim(height_setting, lcas_pkg::MAX_HEIGHT) + 2;
      c = column_pos;
      r = row_pos;
      alive = alive_in;
      if (start) begin
         c = 0;
         r = 0;
      end
      if (c >= padded_w) begin
         c = 0;
         r++;
      end
      if (r >= padded_h) r = 0;
      if (c == 0 || r == 0 || c == padded_w - 1 || r == padded_h - 1) alive = 1'b0;
      top = upper_line[c];
      mid = middle_line[c];
      neighborhood = ((neighborhood << 1) & 9'h1B6) | {2'b00, alive, 2'b00, mid, 2'b00, top};
      upper_line[c] = mid;
      middle_line[c] = alive;
      if (r >= 2 && c >= 2) begin
         live_neighbors = lcas_pkg::COUNT_WIDTH'($countones(neighborhood & ~9'h010));
         outcome.next_alive = (live_neighbors == lcas_pkg::BIRTH_COUNT) ||
                              (neighborhood[4] && live_neighbors == lcas_pkg::SURVIVE_COUNT);
         outcome.out_column = lcas_pkg::COORD_WIDTH'(c - 2);
         outcome.out_row = lcas_pkg::COORD_WIDTH'(r - 2);
         outcome.last_of_frame = (r == padded_h - 1) && (c == padded_w - 1);
         expected_next_states.push_back(outcome);
      end
      c++;
      if (c >= padded_w) begin
         c = 0;
         r++;
         if (r >= padded_h) r = 0;
      end
      column_pos = c;
      row_pos = r;
   endfunction

   int burst_left;
   int gap_left;

   always @(posedge clock) begin : cell_driver
      cell_beat_type beat;
      if (reset) begin
         req.valid <= 1'b0;
         req.cell_alive <= 1'b0;
         req.start_of_frame <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req.valid && req.ready) advance_cell(req.cell_alive, req.start_of_frame);
         if (!req.valid || req.ready) begin
            if (gap_left != 0) begin
               gap_left--;
               req.valid <= 1'b0;
            end else if (cells_to_send.size() != 0) begin
               beat = cells_to_send.pop_front();
               req.valid <= 1'b1;
               req.cell_alive <= beat.cell_alive;
               req.start_of_frame <= beat.start_of_frame;
               if (burst_left != 0) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 400)
                                                          : $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 6) == 0) ? $urandom_range(4, 12)
                                                        : $urandom_range(0, 3);
               end
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   ready_pattern_type ready_pattern;
   int pattern_left;
   int hold_left;
   logic long_hold_done;
   int unsigned stall_cycle;

   always @(posedge clock) begin : result_monitor
      lcas_pkg::result_type observed;
      lcas_pkg::result_type wanted;
      if (reset) begin
         rsp.ready <= 1'b0;
         ready_pattern = READY_ALWAYS;
         pattern_left = 0;
         hold_left = 0;
         long_hold_done = 1'b0;
         stall_cycle = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            observed = '{rsp.next_alive, rsp.out_column, rsp.out_row, rsp.last_of_frame};
            if (expected_next_states.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result: alive %0b column %0d row %0d last %0b",
                           observed.next_alive, observed.out_column, observed.out_row,
                           observed.last_of_frame);
            end else begin
               wanted = expected_next_states.pop_front();
               if (observed != wanted) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: expected alive %0b column %0d row %0d last %0b, %s",
                              wanted.next_alive, wanted.out_column, wanted.out_row,
                              wanted.last_of_frame,
                              $sformatf("got alive %0b column %0d row %0d last %0b",
                                        observed.next_alive, observed.out_column,
                                        observed.out_row, observed.last_of_frame));
               end
            end
         end
         // Once, when at least 150 cells still wait, hold the result channel off so the block backs up.
         if (!long_hold_done && cells_to_send.size() >= 150) begin
            long_hold_done = 1'b1;
            hold_left = 1000;
         end
         stall_cycle++;
         if (pattern_left == 0) begin
            ready_pattern = ready_pattern_type'($urandom_range(0, 3));
            pattern_left = $urandom_range(16, 160);
         end else begin
            pattern_left--;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else begin
            case (ready_pattern)
               READY_ALWAYS: rsp.ready <= 1'b1;
               READY_COIN: rsp.ready <= 1'($urandom_range(0, 1));
               READY_SPARSE: rsp.ready <= ($urandom_range(0, 3) == 0);
               default: rsp.ready <= (stall_cycle % 5 != 0);
            endcase
         end
      end
   end

   task automatic write_register(lcas_pkg::csr_index_type index,
                                 logic [lcas_pkg::CFG_WIDTH-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      if (index == lcas_pkg::REG_FRAME_WIDTH) width_setting = value;
      else height_setting = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_frame(logic [lcas_pkg::CFG_WIDTH-1:0] frame_w,
                            logic [lcas_pkg::CFG_WIDTH-1:0] frame_h);
      write_register(lcas_pkg::REG_FRAME_WIDTH, frame_w);
      write_register(lcas_pkg::REG_FRAME_HEIGHT, frame_h);
   endtask

   task automatic drain();
      do @(negedge clock);
      while (cells_to_send.size() != 0 || req.valid || expected_next_states.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   function automatic void queue_cells(int count, logic with_start, int density);
      cell_beat_type beat;
      for (int i = 0; i < count; i++) begin
         beat.cell_alive = ($urandom_range(0, 99) < density);
         beat.start_of_frame = (i == 0) ? with_start : ($urandom_range(0, 299) == 0);
         cells_to_send.push_back(beat);
      end
   endfunction

   task automatic run_phase(input logic [lcas_pkg::CFG_WIDTH-1:0] frame_w,
                            input logic [lcas_pkg::CFG_WIDTH-1:0] frame_h,
                            input int frames, input logic with_partial, output int queued);
      int frame_cells;
      int cell_count;
      int density;
      logic with_start;
      frame_cells = (clamp_dim(frame_w, MAX_WIDTH) + 2)
                    * (clamp_dim(frame_h, lcas_pkg::MAX_HEIGHT) + 2);
      set_frame(frame_w, frame_h);
      queued = 0;
      for (int f = 0; f < frames; f++) begin
         cell_count = frame_cells;
         density = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) * 100
                                               : $urandom_range(15, 65);
         if (frame_cells > 200) begin
            with_start = 1'b1;
         end else begin
            with_start = (f == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 5) == 0) cell_count = $urandom_range(1, frame_cells - 1);
         end
         queue_cells(cell_count, with_start, density);
         queued += cell_count;
      end
      if (with_partial) begin
         cell_count = $urandom_range(1, frame_cells);
         queue_cells(cell_count, 1'($urandom_range(0, 1)), $urandom_range(15, 65));
         queued += cell_count;
      end
      drain();
   endtask

   initial begin : stimulus
      cell_beat_type beat;
      logic [8:0] interior_pattern;
      int total_cells;
      int phase_cells;
      logic [lcas_pkg::CFG_WIDTH-1:0] frame_w;
      logic [lcas_pkg::CFG_WIDTH-1:0] frame_h;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = lcas_pkg::REG_FRAME_WIDTH;
      csr_data = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Smallest frame with live border cells, which must be read as dead.
      set_frame(lcas_pkg::CFG_WIDTH'(lcas_pkg::MIN_DIM), lcas_pkg::CFG_WIDTH'(lcas_pkg::MIN_DIM));
      interior_pattern = 9'b101_110_011;
      for (int r = 0; r < 5; r++) begin
         for (int c = 0; c < 5; c++) begin
            if (r == 0 || c == 0 || r == 4 || c == 4) beat.cell_alive = 1'b1;
            else beat.cell_alive = interior_pattern[(r - 1) * 3 + (c - 1)];
            beat.start_of_frame = (r == 0 && c == 0);
            cells_to_send.push_back(beat);
         end
      end
      drain();
      total_cells = 25;

      run_phase(11'd0, 11'd2, 2, 1'b1, phase_cells);
      total_cells += phase_cells;
      run_phase(11'd40, 11'd0, 1, 1'b0, phase_cells);
      total_cells += phase_cells;

      // Part of a row at the widest frame; the next narrow frame wraps the counters unless it opens with a start.
      set_frame(11'd2047, 11'd1);
      queue_cells(150, 1'b1, 40);
      drain();
      total_cells += 150;

      while (total_cells < 1100) begin
         frame_w = ($urandom_range(0, 7) == 0) ? lcas_pkg::CFG_WIDTH'($urandom_range(0, 2))
                                               : lcas_pkg::CFG_WIDTH'($urandom_range(3, 14));
         frame_h = ($urandom_range(0, 7) == 0) ? lcas_pkg::CFG_WIDTH'($urandom_range(0, 2))
                                               : lcas_pkg::CFG_WIDTH'($urandom_range(3, 10));
         run_phase(frame_w, frame_h, $urandom_range(1, 2), ($urandom_range(0, 4) < 2),
                   phase_cells);
         total_cells += phase_cells;
      end

      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin : watchdog
      #1600000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

FILE: life_cellular_automaton_stencil.f
rtl/lcas_pkg.sv
rtl/lcas_req_if.sv
rtl/lcas_rsp_if.sv
rtl/lcas_rsp_queue.sv
rtl/life_cellular_automaton_stencil.sv
sim/life_cellular_automaton_stencil_test.sv
